FILE: rtl/integer_to_ascii_formatter_defines.svh
// Assertion macros used by the RTL datapath (i2a_dp).
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define I2A_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define I2A_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/i2a_pkg.sv
package i2a_pkg;

	typedef enum logic [1:0] {
		CMD_SDEC = 2'd0,
		CMD_UDEC = 2'd1,
		CMD_HEX  = 2'd2,
		CMD_PTR  = 2'd3
	} mode_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [3:0] DIG_TEN  = 4'ha;
	localparam logic [3:0] DIG_FIVE = 4'h5;
	localparam logic [3:0] DIG_ADJ  = 4'h3;

	typedef struct packed {
		logic load;
		logic dabble;
		logic norm;
		logic setup;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic hex;
		logic bits_done;
		logic norm_done;
		logic emit_last;
	} dp_sts_t;

endpackage

FILE: rtl/i2a_ctrl.sv
module i2a_ctrl import i2a_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DABBLE = 4'b0010,
		S_NORM   = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DABBLE;
				end
			end
			S_DABBLE: begin
				if (sts.hex) begin
					state_nxt = S_NORM;
				end else begin
					cmd.dabble = 1'b1;
					if (sts.bits_done) state_nxt = S_NORM;
				end
			end
			S_NORM: begin
				if (sts.norm_done) begin
					cmd.setup = 1'b1;
					state_nxt = S_EMIT;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/i2a_dp.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_dp import i2a_pkg::*; #(
	parameter int MAX_DIGITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  mode,
	input  logic [63:0] value,
	input  logic        wide,
	input  logic [4:0]  pad_width,
	output logic        strobe,
	output logic [7:0]  char_out,
	output logic        last
);

	localparam int DW  = 4 * MAX_DIGITS;
	localparam int EW  = (DW > 64) ? DW : 64;
	localparam int NDW = $clog2(MAX_DIGITS + 1);

	logic [63:0]    val_q;
	logic [DW-1:0]  dig_q;
	logic [NDW-1:0] nd_q;
	logic [5:0]     bit_cnt_q;
	logic [1:0]     pre_cnt_q;
	logic [4:0]     pad_q;
	logic [4:0]     width_q;
	logic           neg_q;
	logic           ovf_q;
	mode_t          mode_q;
	logic           strobe_q, last_q;
	logic [7:0]     char_q;

	logic [63:0]    v_ext, mag;
	logic           neg;
	logic [EW-1:0]  mag_ext;
	logic [DW-1:0]  dig_adj;
	logic [3:0]     top;
	logic [5:0]     tot;
	logic [7:0]     ch;
	logic           pre_left, pad_left;

	always_comb begin
		if (wide) v_ext = value;
		else if (mode_t'(mode) == CMD_SDEC) v_ext = {{32{value[31]}}, value[31:0]};
		else v_ext = {32'd0, value[31:0]};
		neg     = (mode_t'(mode) == CMD_SDEC) && v_ext[63];
		mag     = neg ? (64'd0 - v_ext) : v_ext;
		mag_ext = EW'(mag);
	end

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dig_adj[4*i +: 4] = (dig_q[4*i +: 4] >= DIG_FIVE) ?
				dig_q[4*i +: 4] + DIG_ADJ : dig_q[4*i +: 4];
		end
	end

	assign top      = dig_q[DW-1 -: 4];
	assign tot      = 6'(pre_cnt_q) + 6'(nd_q);
	assign pre_left = (pre_cnt_q != 2'd0);
	assign pad_left = (pad_q != 5'd0);

	always_comb begin
		if (pre_left) begin
			if (neg_q) ch = CH_MINUS;
			else if (pre_cnt_q == 2'd2) ch = CH_ZERO;
			else ch = CH_X;
		end else if (pad_left) begin
			ch = CH_ZERO;
		end else if (top < DIG_TEN) begin
			ch = CH_ZERO + 8'(top);
		end else begin
			ch = CH_A + 8'(top - DIG_TEN);
		end
	end

	// value wider than the digit buffer keeps all MAX_DIGITS low digits
	assign sts.hex       = mode_q[1];
	assign sts.bits_done = &bit_cnt_q;
	assign sts.norm_done = ovf_q || (top != 4'd0) || (nd_q == NDW'(1));
	assign sts.emit_last = !pre_left && !pad_left && (nd_q == NDW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q     <= mag;
			dig_q     <= mode[1] ? mag_ext[DW-1:0] : '0;
			nd_q      <= NDW'(MAX_DIGITS);
			bit_cnt_q <= 6'd0;
			neg_q     <= neg;
			ovf_q     <= mode[1] && ((mag >> DW) != 64'd0);
			mode_q    <= mode_t'(mode);
			width_q   <= pad_width;
			pre_cnt_q <= neg ? 2'd1 : ((mode_t'(mode) == CMD_PTR) ? 2'd2 : 2'd0);
		end else if (cmd.dabble) begin
			dig_q     <= {dig_adj[DW-2:0], val_q[63]};
			val_q     <= {val_q[62:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + 6'd1;
			ovf_q     <= ovf_q | dig_adj[DW-1];
		end else if (cmd.norm) begin
			dig_q <= {dig_q[DW-5:0], 4'd0};
			nd_q  <= nd_q - NDW'(1);
		end else if (cmd.setup) begin
			pad_q <= (tot < 6'(width_q)) ? 5'(6'(width_q) - tot) : 5'd0;
		end else if (cmd.emit) begin
			if (pre_left) begin
				pre_cnt_q <= pre_cnt_q - 2'd1;
			end else if (pad_left) begin
				pad_q <= pad_q - 5'd1;
			end else begin
				dig_q <= {dig_q[DW-5:0], 4'd0};
				nd_q  <= nd_q - NDW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= ch;
			last_q <= sts.emit_last;
		end
	end

	assign strobe   = strobe_q;
	assign char_out = char_q;
	assign last     = last_q;

	`I2A_ASSERT_NXT(a_emit_strobe, cmd.emit, strobe_q, "emit without strobe")
	`I2A_ASSERT_NXT(a_last_gap, strobe_q && last_q, !strobe_q, "item overlap after last")
	`I2A_ASSERT_IMP(a_nd_nonzero, cmd.emit || cmd.norm, nd_q != '0, "digit count ran out")

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// Formats one 64-bit integer per item as ASCII, most significant character
// first, one character per cycle on char_out with char_valid high and last on
// the final one. The receiver cannot stall: characters appear whether or not
// it is ready. Decimal items go through shift-add-3 BCD conversion, which hex
// and pointer items skip; then up to MAX_DIGITS - 1 leading zero digits are
// stripped, padding is set up, and the characters are issued. Busy stays high
// until the last character is issued.
module integer_to_ascii_formatter import i2a_pkg::*; #(
	parameter int MAX_DIGITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] value,
	input  logic        wide,
	input  logic [4:0]  pad_width,
	output logic        char_valid,
	output logic [7:0]  char_out,
	output logic        last
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	i2a_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	i2a_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.mode      (cmd),
		.value     (value),
		.wide      (wide),
		.pad_width (pad_width),
		.strobe    (char_valid),
		.char_out  (char_out),
		.last      (last)
	);

endmodule

FILE: bench/integer_to_ascii_formatter_checker.sv
`timescale 1ns / 100ps
module integer_to_ascii_formatter_checker import i2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] value,
	input  logic        wide,
	input  logic [4:0]  pad_width,
	input  logic        char_valid,
	input  logic [7:0]  char_out,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          chars_seen
);

	localparam int DIGIT_CAP = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} char_exp_t;

	char_exp_t char_q[$];
	char_exp_t want;

	// Expand one number into the characters it should produce.
	function automatic void format_number(input mode_t m, input logic [63:0] raw,
			input logic w, input logic [4:0] pw);
		logic [63:0] mag;
		logic [7:0]  lead [0:1];
		logic [7:0]  digs [0:DIGIT_CAP-1];
		logic [7:0]  c;
		int          n_lead, n_dig, n_pad, total, radix, rem;
		mag = w ? raw : {32'h0, raw[31:0]};
		if (!w && m == CMD_SDEC && raw[31]) begin
			mag[63:32] = '1;
		end
		n_lead = 0;
		n_dig = 0;
		if (m == CMD_SDEC && mag[63]) begin
			lead[0] = CH_MINUS;
			n_lead = 1;
			mag = -mag;
		end else if (m == CMD_PTR) begin
			lead[0] = CH_ZERO;
			lead[1] = CH_X;
			n_lead = 2;
		end
		radix = (m == CMD_HEX || m == CMD_PTR) ? 16 : 10;
		do begin
			rem = int'(mag % 64'(radix));
			digs[n_dig] = (rem < int'(DIG_TEN)) ? CH_ZERO + 8'(rem)
				: CH_A + 8'(rem - int'(DIG_TEN));
			mag = mag / 64'(radix);
			n_dig++;
		end while (mag != 0 && n_dig < DIGIT_CAP);
		n_pad = (int'(pw) > n_lead + n_dig) ? int'(pw) - n_lead - n_dig : 0;
		total = n_lead + n_pad + n_dig;
		for (int i = 0; i < total; i++) begin
			if (i < n_lead) begin
				c = lead[i];
			end else if (i < n_lead + n_pad) begin
				c = CH_ZERO;
			end else begin
				c = digs[total - 1 - i];
			end
			char_q.push_back('{ch: c, is_last: (i == total - 1)});
		end
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		chars_seen = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid) begin
				if (char_q.size() == 0) begin
					$error("unexpected character %h, last %b", char_out, last);
					errors++;
				end else begin
					want = char_q.pop_front();
					if (char_out !== want.ch) begin
						$error("char_out: expected %h, got %h", want.ch, char_out);
						errors++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %b, got %b", want.is_last, last);
						errors++;
					end
					chars_seen++;
				end
			end
			if (start && !busy) begin
				format_number(mode_t'(cmd), value, wide, pad_width);
			end
			pending = char_q.size();
		end
	end

endmodule

FILE: bench/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps
module integer_to_ascii_formatter_tb;
	import i2a_pkg::*;

	localparam int RANDOM_ITEMS = 220;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [63:0] value;
	logic        wide;
	logic [4:0]  pad_width;
	logic        char_valid;
	logic [7:0]  char_out;
	logic        last;
	int          errors;
	int          pending;
	int          chars_seen;
	int          items_sent;
	int          cycles;
	int          burst_left;

	integer_to_ascii_formatter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value      (value),
		.wide       (wide),
		.pad_width  (pad_width),
		.char_valid (char_valid),
		.char_out   (char_out),
		.last       (last)
	);

	integer_to_ascii_formatter_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value      (value),
		.wide       (wide),
		.pad_width  (pad_width),
		.char_valid (char_valid),
		.char_out   (char_out),
		.last       (last),
		.errors     (errors),
		.pending    (pending),
		.chars_seen (chars_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic send_number(input mode_t c, input logic [63:0] v, input logic w,
			input logic [4:0] p);
		start <= 1'b1;
		cmd <= c;
		value <= v;
		wide <= w;
		pad_width <= p;
		do @(posedge clk); while (!(start && !busy));
		items_sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			start <= 1'b0;
			if ($urandom_range(0, 1) == 0) begin
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				repeat ($urandom_range(9, 130)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 4);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 6))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(0, 20));
			2: return 64'h1 << $urandom_range(0, 63);
			3: return {$urandom, $urandom} >> $urandom_range(0, 63);
			4: return -64'($urandom_range(1, 1000));
			5: return {$urandom, 1'b1, 31'($urandom)};
			default: return ~(64'h0) << $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [4:0] pick_width();
		case ($urandom_range(0, 3))
			0: return 5'd0;
			1: return 5'd31;
			2: return 5'($urandom_range(0, 31));
			default: return 5'($urandom_range(0, 8));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_SDEC;
		value = '0;
		wide = 1'b0;
		pad_width = '0;
		burst_left = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_number(CMD_SDEC, 64'h0, 1'b1, 5'd0);
		send_number(CMD_SDEC, 64'h8000_0000_0000_0000, 1'b1, 5'd0);
		send_number(CMD_SDEC, 64'h7fff_ffff_ffff_ffff, 1'b1, 5'd31);
		send_number(CMD_SDEC, 64'hdead_beef_8000_0000, 1'b0, 5'd0);
		send_number(CMD_SDEC, 64'h1234_5678_ffff_ffff, 1'b0, 5'd5);
		send_number(CMD_SDEC, 64'hffff_ffff_7fff_ffff, 1'b0, 5'd10);
		send_number(CMD_SDEC, -64'd5, 1'b1, 5'd4);
		send_number(CMD_SDEC, 64'h1, 1'b1, 5'd1);
		send_number(CMD_UDEC, 64'hffff_ffff_ffff_ffff, 1'b1, 5'd31);
		send_number(CMD_UDEC, 64'hffff_ffff_ffff_ffff, 1'b0, 5'd0);
		send_number(CMD_UDEC, 64'h0, 1'b0, 5'd31);
		send_number(CMD_UDEC, 64'd12345, 1'b1, 5'd3);
		send_number(CMD_HEX, 64'h0, 1'b1, 5'd0);
		send_number(CMD_HEX, 64'hffff_ffff_ffff_ffff, 1'b1, 5'd16);
		send_number(CMD_HEX, 64'hffff_ffff_0000_abcd, 1'b0, 5'd2);
		send_number(CMD_HEX, 64'h0123_4567_89ab_cdef, 1'b1, 5'd31);
		send_number(CMD_PTR, 64'h0, 1'b1, 5'd0);
		send_number(CMD_PTR, 64'hffff_ffff_8000_0000, 1'b0, 5'd12);
		send_number(CMD_PTR, 64'hffff_ffff_ffff_ffff, 1'b1, 5'd31);
		send_number(CMD_PTR, 64'h5, 1'b1, 5'd2);
		drain();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2) begin
				drain();
			end
			send_number(mode_t'($urandom_range(0, 3)), pick_value(),
				1'($urandom_range(0, 1)), pick_width());
		end
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);

		$display("Formatted %0d numbers in signed, unsigned, hex and pointer modes,", items_sent);
		$display("narrow and wide, pad widths 0..31; %0d characters checked", chars_seen);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_ctrl.sv
rtl/i2a_dp.sv
rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_checker.sv
bench/integer_to_ascii_formatter_tb.sv
